@@ rtl/ntm_pkg.sv @@
// ----------------------------------------------------------------------------
// ntm_pkg: shared types and constants for the trigger matcher
// Item structs, table entry layout, action codes and table sizing.
// ----------------------------------------------------------------------------
package ntm_pkg;

    // Number of trigger entries the pending table holds
    localparam int TRIGGER_DEPTH = 16;
    // Counter width: holds 0 .. TRIGGER_DEPTH
    localparam int CNT_W = $clog2(TRIGGER_DEPTH + 1);
    // Index width: addresses 0 .. TRIGGER_DEPTH-1
    localparam int IDX_W = (TRIGGER_DEPTH > 1) ? $clog2(TRIGGER_DEPTH) : 1;

    // Action codes
    localparam logic [1:0] ACT_TRIGGER = 2'd0;
    localparam logic [1:0] ACT_FRAME   = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] trig_seq_no;
        logic [63:0] trigger_mcu_us;
        logic [63:0] trigger_host_us;
        logic [63:0] frame_host_us;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  slot;
        logic [31:0] matched_seq;
        logic [63:0] matched_mcu_us;
        logic [63:0] matched_host_us;
        logic [63:0] paired_frame_us;
        logic [63:0] paired_frame_number;
        logic [15:0] paired_width;
        logic [15:0] paired_height;
        logic [31:0] trigger_overflows;
    } out_item_t;

    // One pending trigger
    typedef struct packed {
        logic [31:0] seq;
        logic [63:0] mcu_us;
        logic [63:0] host_us;
    } entry_t;

    // Table write port
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

    // Distance unit result
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [63:0]      delta;
        entry_t           entry;
    } dist_t;

endpackage

@@ rtl/nearest_timestamp_trigger_matcher.sv @@
// ----------------------------------------------------------------------------
// nearest_timestamp_trigger_matcher: pairs frames with the nearest trigger
//
// Input words (s_valid/s_ready, s_data) carry a trigger, a frame or a
// restart. Triggers go into a table of TRIGGER_DEPTH entries in arrival
// order; a trigger that finds the table full is dropped and counted.
// A frame with pending triggers is matched to the entry whose host time is
// closest (oldest wins a tie); the record leaves on m_valid/m_ready.
// Triggers, restarts and frames that find the table empty are handled in
// the idle state. A frame with pending entries is walked through the shared
// distance unit (one table read per cycle, two register stages), the record
// is loaded, and the gap is closed one table word per cycle over the single
// read and write port.
// s_ready is low while a frame is in progress. If the receiver stalls,
// the record is held and the next matched frame waits before its record
// is loaded. Synchronous active-low reset empties the table and clears
// both counters and the slot register (cfg_we/cfg_wdata).
// ----------------------------------------------------------------------------
module nearest_timestamp_trigger_matcher
    import ntm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);

    tbl_wr_t          tbl_wr;
    logic [IDX_W-1:0] tbl_raddr;
    entry_t           tbl_rdata;
    logic             rd_valid;
    logic [IDX_W-1:0] rd_idx;
    logic [63:0]      frame_us;
    dist_t            dist_res;

    ntm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .tbl_wr    (tbl_wr),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata),
        .rd_valid  (rd_valid),
        .rd_idx    (rd_idx),
        .frame_us  (frame_us),
        .dist_in   (dist_res)
    );

    ntm_table u_table (
        .aclk  (aclk),
        .wr    (tbl_wr),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    ntm_absdiff u_absdiff (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_valid),
        .in_idx   (rd_idx),
        .in_entry (tbl_rdata),
        .ref_us   (frame_us),
        .result   (dist_res)
    );

endmodule

@@ rtl/ntm_table.sv @@
// ----------------------------------------------------------------------------
// ntm_table: pending trigger table
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ntm_table
    import ntm_pkg::*;
(
    input  logic             aclk,
    input  tbl_wr_t          wr,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [TRIGGER_DEPTH];
    entry_t rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ntm_absdiff.sv @@
// ----------------------------------------------------------------------------
// ntm_absdiff: shared distance unit
// Absolute difference of an entry's host time and the frame time, registered,
// with the entry and its index carried alongside.
// ----------------------------------------------------------------------------
module ntm_absdiff
    import ntm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [IDX_W-1:0] in_idx,
    input  entry_t           in_entry,
    input  logic [63:0]      ref_us,
    output dist_t            result
);

    logic [64:0] diff_ab;
    logic [63:0] diff_ba;
    logic [63:0] dist_next;
    dist_t       result_reg;

    // both subtractions in parallel, borrow picks the positive one
    always_comb begin
        diff_ab   = {1'b0, in_entry.host_us} - {1'b0, ref_us};
        diff_ba   = ref_us - in_entry.host_us;
        dist_next = diff_ab[64] ? diff_ba : diff_ab[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_reg.valid <= 1'b0;
        end else begin
            result_reg.valid <= in_valid;
        end
        result_reg.idx   <= in_idx;
        result_reg.delta <= dist_next;
        result_reg.entry <= in_entry;
    end

    assign result = result_reg;

endmodule

@@ rtl/ntm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ntm_ctrl: matcher sequencer
// Accepts words, keeps counters, walks the table through the distance unit,
// emits the record and closes the gap left by the matched entry.
// ----------------------------------------------------------------------------
module ntm_ctrl
    import ntm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_wdata,
    output tbl_wr_t          tbl_wr,
    output logic [IDX_W-1:0] tbl_raddr,
    input  entry_t           tbl_rdata,
    output logic             rd_valid,
    output logic [IDX_W-1:0] rd_idx,
    output logic [63:0]      frame_us,
    input  dist_t            dist_in
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_SHIFT
    } state_t;

    state_t           state_reg,     state_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [63:0]      frame_cnt_reg, frame_cnt_next;
    logic [31:0]      ovf_reg,       ovf_next;
    logic [1:0]       slot_reg,      slot_next;
    logic [CNT_W-1:0] scan_idx_reg,  scan_idx_next;
    logic             p1_valid_reg,  p1_valid_next;
    logic [IDX_W-1:0] p1_idx_reg,    p1_idx_next;
    logic [CNT_W-1:0] shift_rd_reg,  shift_rd_next;
    logic             sh_pend_reg,   sh_pend_next;
    logic [IDX_W-1:0] sh_waddr_reg,  sh_waddr_next;
    logic             m_valid_reg,   m_valid_next;

    in_item_t         item_reg,      item_next;
    logic [63:0]      fnum_reg,      fnum_next;
    logic [IDX_W-1:0] best_idx_reg,  best_idx_next;
    logic [63:0]      best_dist_reg, best_dist_next;
    entry_t           best_ent_reg,  best_ent_next;
    out_item_t        m_data_reg,    m_data_next;

    logic             accept;
    logic [CNT_W-1:0] last_idx;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign last_idx = count_reg - CNT_W'(1);

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign rd_valid = p1_valid_reg;
    assign rd_idx   = p1_idx_reg;
    assign frame_us = item_reg.frame_host_us;

    // table ports: trigger insert in idle, gap close in shift
    always_comb begin
        tbl_wr.we   = 1'b0;
        tbl_wr.addr = count_reg[IDX_W-1:0];
        tbl_wr.data = '{seq:     s_data.trig_seq_no,
                        mcu_us:  s_data.trigger_mcu_us,
                        host_us: s_data.trigger_host_us};
        if (state_reg == ST_SHIFT) begin
            tbl_wr.we   = sh_pend_reg;
            tbl_wr.addr = sh_waddr_reg;
            tbl_wr.data = tbl_rdata;
        end else if (accept && s_data.action == ACT_TRIGGER &&
                     count_reg < CNT_W'(TRIGGER_DEPTH)) begin
            tbl_wr.we = 1'b1;
        end
        tbl_raddr = (state_reg == ST_SHIFT) ? shift_rd_reg[IDX_W-1:0]
                                            : scan_idx_reg[IDX_W-1:0];
    end

    // next-state logic
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        frame_cnt_next = frame_cnt_reg;
        ovf_next       = ovf_reg;
        slot_next      = cfg_we ? cfg_wdata : slot_reg;
        scan_idx_next  = scan_idx_reg;
        p1_valid_next  = 1'b0;
        p1_idx_next    = p1_idx_reg;
        shift_rd_next  = shift_rd_reg;
        sh_pend_next   = 1'b0;
        sh_waddr_next  = sh_waddr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        item_next      = item_reg;
        fnum_next      = fnum_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        best_ent_next  = best_ent_reg;
        m_data_next    = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    item_next = s_data;
                    case (s_data.action)
                        ACT_TRIGGER: begin
                            if (count_reg < CNT_W'(TRIGGER_DEPTH)) begin
                                count_next = count_reg + CNT_W'(1);
                            end else if (ovf_reg != '1) begin
                                ovf_next = ovf_reg + 32'd1;
                            end
                        end
                        ACT_FRAME: begin
                            fnum_next      = frame_cnt_reg;
                            frame_cnt_next = frame_cnt_reg + 64'd1;
                            scan_idx_next  = '0;
                            if (count_reg != '0) begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_RESTART: begin
                            count_next     = '0;
                            frame_cnt_next = '0;
                            ovf_next       = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // issue reads in order
                if (scan_idx_reg < count_reg) begin
                    p1_valid_next = 1'b1;
                    p1_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                // strict compare keeps the oldest on a tie
                if (dist_in.valid) begin
                    if (dist_in.idx == '0 || dist_in.delta < best_dist_reg) begin
                        best_idx_next  = dist_in.idx;
                        best_dist_next = dist_in.delta;
                        best_ent_next  = dist_in.entry;
                    end
                    if (CNT_W'(dist_in.idx) == last_idx) begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{slot:                slot_reg,
                                     matched_seq:         best_ent_reg.seq,
                                     matched_mcu_us:      best_ent_reg.mcu_us,
                                     matched_host_us:     best_ent_reg.host_us,
                                     paired_frame_us:     item_reg.frame_host_us,
                                     paired_frame_number: fnum_reg,
                                     paired_width:        item_reg.frame_width,
                                     paired_height:       item_reg.frame_height,
                                     trigger_overflows:   ovf_reg};
                    shift_rd_next = CNT_W'(best_idx_reg) + CNT_W'(1);
                    state_next    = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                // read entry j, write it to j-1 in the next cycle
                if (shift_rd_reg < count_reg) begin
                    sh_pend_next  = 1'b1;
                    sh_waddr_next = shift_rd_reg[IDX_W-1:0] - IDX_W'(1);
                    shift_rd_next = shift_rd_reg + CNT_W'(1);
                end else if (!sh_pend_reg) begin
                    count_next = last_idx;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            frame_cnt_reg <= '0;
            ovf_reg       <= '0;
            slot_reg      <= '0;
            scan_idx_reg  <= '0;
            p1_valid_reg  <= 1'b0;
            p1_idx_reg    <= '0;
            shift_rd_reg  <= '0;
            sh_pend_reg   <= 1'b0;
            sh_waddr_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            frame_cnt_reg <= frame_cnt_next;
            ovf_reg       <= ovf_next;
            slot_reg      <= slot_next;
            scan_idx_reg  <= scan_idx_next;
            p1_valid_reg  <= p1_valid_next;
            p1_idx_reg    <= p1_idx_next;
            shift_rd_reg  <= shift_rd_next;
            sh_pend_reg   <= sh_pend_next;
            sh_waddr_reg  <= sh_waddr_next;
            m_valid_reg   <= m_valid_next;
        end
        item_reg      <= item_next;
        fnum_reg      <= fnum_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        best_ent_reg  <= best_ent_next;
        m_data_reg    <= m_data_next;
    end

endmodule
